>>> rtl/core/utf8_text_offset_mapper_defines.svh
// assertion macros for the utf8 text offset mapper
`ifndef UTF8_TEXT_OFFSET_MAPPER_DEFINES_SVH
`define UTF8_TEXT_OFFSET_MAPPER_DEFINES_SVH

// same-cycle implication, checked on clk and held off during reset
`define UTOM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk and held off during reset
`define UTOM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/utom_pkg.sv
// shared constants, command codes and types of the utf8 text offset mapper
`default_nettype none

package utom_pkg;

	localparam int unsigned TEXT_DEPTH = 65536;
	localparam int unsigned ADDR_W     = $clog2(TEXT_DEPTH);
	localparam int unsigned LEN_W      = ADDR_W + 1;
	localparam int unsigned OFF_W      = 17;

	localparam logic [7:0] NEWLINE = 8'h0A;

	localparam logic [2:0] CMD_CLEAR         = 3'd0;
	localparam logic [2:0] CMD_APPEND        = 3'd1;
	localparam logic [2:0] CMD_UTF16_OF_BYTE = 3'd2;
	localparam logic [2:0] CMD_BYTE_OF_UTF16 = 3'd3;
	localparam logic [2:0] CMD_POS_OF_BYTE   = 3'd4;
	localparam logic [2:0] CMD_BYTE_OF_POS   = 3'd5;

	typedef struct packed {
		logic              status;
		logic [OFF_W-1:0]  result_offset;
		logic [OFF_W-1:0]  line_number;
		logic [OFF_W-1:0]  column_units;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [2:0]        mode;
		logic [OFF_W-1:0]  target;
		logic [OFF_W-1:0]  chr;
	} walk_req_t;

	typedef struct packed {
		logic              done;
		logic [OFF_W-1:0]  result_offset;
		logic [OFF_W-1:0]  line_number;
		logic [OFF_W-1:0]  column_units;
	} walk_rsp_t;

	typedef struct packed {
		logic [LEN_W-1:0]  next_at;
		logic [1:0]        units;
		logic              is_nl;
	} step_t;

endpackage

`default_nettype wire

>>> rtl/core/utom_chan_if.sv
// valid/ready channels for request and result items
`default_nettype none

interface utom_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [7:0]  data_byte;
	logic [16:0] query_offset;
	logic signed [17:0] line_index;
	logic [16:0] char_index;

	modport source(output valid, command, data_byte, query_offset, line_index, char_index,
		input ready);
	modport sink(input valid, command, data_byte, query_offset, line_index, char_index,
		output ready);
endinterface

interface utom_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [16:0] result_offset;
	logic [16:0] line_number;
	logic [16:0] column_units;

	modport source(output valid, status, result_offset, line_number, column_units,
		input ready);
	modport sink(input valid, status, result_offset, line_number, column_units,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/utom_step_unit.sv
// shared step unit: sequence width, utf16 units and newline of one lead byte
`default_nettype none

module utom_step_unit (
	input  wire logic [7:0]                 lead,
	input  wire logic [utom_pkg::LEN_W-1:0] at,
	input  wire logic [utom_pkg::LEN_W-1:0] text_len,
	output utom_pkg::step_t                 step
);

	logic [2:0]                 width;
	logic [2:0]                 width_fit;
	logic [utom_pkg::LEN_W-1:0] remain;
	logic                       four_lead;

	always_comb begin
		four_lead = (lead[7:3] == 5'b11110);
		if (!lead[7]) begin
			width = 3'd1;
		end else if (lead[7:5] == 3'b110) begin
			width = 3'd2;
		end else if (lead[7:4] == 4'b1110) begin
			width = 3'd3;
		end else if (four_lead) begin
			width = 3'd4;
		end else begin
			width = 3'd1;
		end
		remain = text_len - at;
		// a sequence cut off by the end of the text moves one byte
		width_fit = (utom_pkg::LEN_W'(width) > remain) ? 3'd1 : width;
		step.next_at = at + utom_pkg::LEN_W'(width_fit);
		step.units   = four_lead ? 2'd2 : 2'd1;
		step.is_nl   = (lead == utom_pkg::NEWLINE);
	end

endmodule

`default_nettype wire

>>> rtl/core/utom_text_ram.sv
// single-port-write, single-port-read text store with registered read data
`default_nettype none

module utom_text_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [utom_pkg::ADDR_W-1:0] waddr,
	input  wire logic [7:0]                  wdata,
	input  wire logic [utom_pkg::ADDR_W-1:0] raddr,
	output logic      [7:0]                  rdata
);

	logic [7:0] mem [utom_pkg::TEXT_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/utom_walker.sv
// sequencer that walks the stored text one utf-8 sequence per step
`default_nettype none

module utom_walker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire utom_pkg::walk_req_t         req,
	input  wire logic [utom_pkg::LEN_W-1:0]  text_len,
	input  wire logic [7:0]                  rd_data,
	output logic      [utom_pkg::ADDR_W-1:0] rd_addr,
	output utom_pkg::walk_rsp_t              rsp,
	output logic                             busy
);

	localparam logic [1:0] W_IDLE  = 2'd0;
	localparam logic [1:0] W_CHECK = 2'd1;
	localparam logic [1:0] W_STEP  = 2'd2;

	logic [1:0]                 state_q;
	logic                       phase_q;
	logic [2:0]                 mode_q;
	logic [utom_pkg::LEN_W-1:0] at_q;
	logic [utom_pkg::OFF_W-1:0] units_q;
	logic [utom_pkg::OFF_W-1:0] line_q;
	logic [utom_pkg::OFF_W-1:0] tgt_q;
	logic [utom_pkg::OFF_W-1:0] chr_q;

	utom_pkg::step_t stp;
	logic            at_lt_len;
	logic            cont;
	logic            line_reached;
	logic            brk;
	logic            fin_check;

	utom_step_unit u_step (
		.lead     (rd_data),
		.at       (at_q),
		.text_len (text_len),
		.step     (stp)
	);

	// read data of the address presented in W_CHECK is there in W_STEP
	assign rd_addr = at_q[utom_pkg::ADDR_W-1:0];
	assign busy    = (state_q != W_IDLE);

	always_comb begin
		at_lt_len    = (at_q < text_len);
		line_reached = (line_q >= tgt_q);
		case (mode_q)
			utom_pkg::CMD_UTF16_OF_BYTE, utom_pkg::CMD_POS_OF_BYTE: begin
				cont = (at_q < utom_pkg::LEN_W'(tgt_q));
			end
			utom_pkg::CMD_BYTE_OF_UTF16: begin
				cont = at_lt_len && (units_q < tgt_q);
			end
			utom_pkg::CMD_BYTE_OF_POS: begin
				cont = phase_q ? (at_lt_len && (units_q < chr_q)) : (!line_reached && at_lt_len);
			end
			default: begin
				cont = 1'b0;
			end
		endcase
		// column search stops on the line's newline without taking it
		brk = (state_q == W_STEP) && (mode_q == utom_pkg::CMD_BYTE_OF_POS) && phase_q
			&& stp.is_nl;
		fin_check = (state_q == W_CHECK) && !cont
			&& !((mode_q == utom_pkg::CMD_BYTE_OF_POS) && !phase_q && line_reached);

		rsp.done          = fin_check || brk;
		rsp.line_number   = '0;
		rsp.column_units  = '0;
		rsp.result_offset = utom_pkg::OFF_W'(at_q);
		case (mode_q)
			utom_pkg::CMD_UTF16_OF_BYTE: begin
				rsp.result_offset = units_q;
			end
			utom_pkg::CMD_POS_OF_BYTE: begin
				rsp.result_offset = '0;
				rsp.line_number   = line_q;
				rsp.column_units  = units_q;
			end
			utom_pkg::CMD_BYTE_OF_POS: begin
				// line past the last line gives the text length
				if (!phase_q) begin
					rsp.result_offset = utom_pkg::OFF_W'(text_len);
				end
			end
			default: begin
				rsp.result_offset = utom_pkg::OFF_W'(at_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			phase_q <= 1'b0;
			mode_q  <= utom_pkg::CMD_CLEAR;
			at_q    <= '0;
			units_q <= '0;
			line_q  <= '0;
			tgt_q   <= '0;
			chr_q   <= '0;
		end else begin
			case (state_q)
				W_IDLE: begin
					if (req.start) begin
						state_q <= W_CHECK;
						phase_q <= 1'b0;
						mode_q  <= req.mode;
						at_q    <= '0;
						units_q <= '0;
						line_q  <= '0;
						tgt_q   <= req.target;
						chr_q   <= req.chr;
					end
				end
				W_CHECK: begin
					if (cont) begin
						state_q <= W_STEP;
					end else if (!fin_check) begin
						phase_q <= 1'b1;
					end else begin
						state_q <= W_IDLE;
					end
				end
				W_STEP: begin
					state_q <= W_CHECK;
					case (mode_q)
						utom_pkg::CMD_UTF16_OF_BYTE, utom_pkg::CMD_BYTE_OF_UTF16: begin
							at_q    <= stp.next_at;
							units_q <= units_q + utom_pkg::OFF_W'(stp.units);
						end
						utom_pkg::CMD_POS_OF_BYTE: begin
							at_q <= stp.next_at;
							if (stp.is_nl) begin
								line_q  <= line_q + 1'b1;
								units_q <= '0;
							end else begin
								units_q <= units_q + utom_pkg::OFF_W'(stp.units);
							end
						end
						utom_pkg::CMD_BYTE_OF_POS: begin
							if (!phase_q) begin
								at_q <= stp.next_at;
								if (stp.is_nl) begin
									line_q <= line_q + 1'b1;
								end
							end else if (brk) begin
								state_q <= W_IDLE;
							end else begin
								at_q    <= stp.next_at;
								units_q <= units_q + utom_pkg::OFF_W'(stp.units);
							end
						end
						default: begin
							state_q <= W_IDLE;
						end
					endcase
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/utf8_text_offset_mapper.sv
// utf8 text offset mapper top level: command decode, text length, text store, result register
// clear, append, unused commands and a negative line: result in the cycle after the item is taken
// walks: one step per utf-8 sequence (store read, then shared step unit); byte-of-position
// moves on from its line search to a column search, which can stop on a newline
// one item at a time; a waiting result holds off the next item until the cycle it is taken
// arst_n empties the text and the result register; the store itself is not cleared
`default_nettype none
`include "utf8_text_offset_mapper_defines.svh"

module utf8_text_offset_mapper (
	input  wire logic clk,
	input  wire logic arst_n,
	utom_req_if.sink  req,
	utom_rsp_if.source rsp
);

	logic [utom_pkg::LEN_W-1:0]  len_q;
	utom_pkg::out_item_t         out_q;
	logic                        out_valid_q;

	logic                        acc;
	logic                        walk_busy;
	logic                        full;
	logic                        line_neg;
	logic                        imm;
	logic                        ram_we;
	logic [utom_pkg::LEN_W-1:0]  qoff_clamped;
	logic [7:0]                  rd_data;
	logic [utom_pkg::ADDR_W-1:0] rd_addr;
	utom_pkg::walk_req_t         walk_req;
	utom_pkg::walk_rsp_t         walk_rsp;
	utom_pkg::out_item_t         imm_item;

	assign req.ready = !walk_busy && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign full      = (len_q >= utom_pkg::LEN_W'(utom_pkg::TEXT_DEPTH));
	assign line_neg  = req.line_index[17];

	always_comb begin
		qoff_clamped = (utom_pkg::LEN_W'(req.query_offset) > len_q) ? len_q
			: utom_pkg::LEN_W'(req.query_offset);
		walk_req.start  = 1'b0;
		walk_req.mode   = req.command;
		walk_req.target = utom_pkg::OFF_W'(qoff_clamped);
		walk_req.chr    = req.char_index;
		imm             = 1'b0;
		ram_we          = 1'b0;
		imm_item        = '0;
		case (req.command)
			utom_pkg::CMD_CLEAR: begin
				imm = acc;
			end
			utom_pkg::CMD_APPEND: begin
				imm             = acc;
				ram_we          = acc && !full;
				imm_item.status = full;
			end
			utom_pkg::CMD_UTF16_OF_BYTE, utom_pkg::CMD_POS_OF_BYTE: begin
				walk_req.start = acc;
			end
			utom_pkg::CMD_BYTE_OF_UTF16: begin
				walk_req.start  = acc;
				walk_req.target = req.query_offset;
			end
			utom_pkg::CMD_BYTE_OF_POS: begin
				// a negative line answers zero without a walk
				walk_req.start  = acc && !line_neg;
				walk_req.target = req.line_index[16:0];
				imm             = acc && line_neg;
			end
			default: begin
				imm = acc;
			end
		endcase
	end

	utom_text_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[utom_pkg::ADDR_W-1:0]),
		.wdata (req.data_byte),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	utom_walker u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (walk_req),
		.text_len (len_q),
		.rd_data  (rd_data),
		.rd_addr  (rd_addr),
		.rsp      (walk_rsp),
		.busy     (walk_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && (req.command == utom_pkg::CMD_CLEAR)) begin
				len_q <= '0;
			end else if (ram_we) begin
				len_q <= len_q + 1'b1;
			end
			if (imm || walk_rsp.done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (imm) begin
			out_q <= imm_item;
		end else if (walk_rsp.done) begin
			out_q.status        <= 1'b0;
			out_q.result_offset <= walk_rsp.result_offset;
			out_q.line_number   <= walk_rsp.line_number;
			out_q.column_units  <= walk_rsp.column_units;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.result_offset = out_q.result_offset;
	assign rsp.line_number   = out_q.line_number;
	assign rsp.column_units  = out_q.column_units;

	`UTOM_ASSERT_NOW(a_walk_done_slot_free, walk_rsp.done, !out_valid_q,
		"walk finished while the result register still held an item")
	`UTOM_ASSERT_NEXT(a_append_grows, ram_we && !walk_busy,
		len_q == $past(len_q) + 1'b1, "append did not grow the text by one byte")
	`UTOM_ASSERT_NOW(a_drop_only_full, out_valid_q && out_q.status,
		len_q == utom_pkg::LEN_W'(utom_pkg::TEXT_DEPTH), "byte dropped while store not full")

endmodule

`default_nettype wire

>>> bench/offset_map_checker.sv
// result checker for the utf8 text offset mapper: mirrors the document, predicts and compares
module offset_map_checker (
	input  logic clk,
	input  logic arst_n,
	utom_req_if  req,
	utom_rsp_if  rsp,
	output int   fault_count,
	output int   answers_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import utom_pkg::*;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	logic [7:0]  doc_text [TEXT_DEPTH];
	int unsigned doc_len;
	out_item_t   answers_due [$];
	out_item_t   want_item, got_item, pred_item;

	function automatic int unsigned lead_span(logic [7:0] b);
		if (!b[7]) return 1;
		if (b[7:5] == 3'b110) return 2;
		if (b[7:4] == 4'b1110) return 3;
		if (b[7:3] == 5'b11110) return 4;
		return 1;
	endfunction

	// a 4-byte lead stands for a surrogate pair, even when cut off
	function automatic int unsigned lead_units16(logic [7:0] b);
		return (b[7:3] == 5'b11110) ? 2 : 1;
	endfunction

	// a sequence running past the end of the text moves one byte
	function automatic int unsigned step_at(int unsigned at);
		int unsigned w;
		w = lead_span(doc_text[at]);
		if (w > doc_len - at) w = 1;
		return w;
	endfunction

	function automatic int unsigned clamp_len(int unsigned v);
		return (v > doc_len) ? doc_len : v;
	endfunction

	function automatic int unsigned utf16_of_byte(int unsigned off);
		int unsigned stop, at, units;
		stop = clamp_len(off);
		at = 0;
		units = 0;
		while (at < stop) begin
			units += lead_units16(doc_text[at]);
			at += step_at(at);
		end
		return units;
	endfunction

	function automatic int unsigned byte_of_utf16(int unsigned u16);
		int unsigned at, units;
		at = 0;
		units = 0;
		while (at < doc_len && units < u16) begin
			units += lead_units16(doc_text[at]);
			at += step_at(at);
		end
		return at;
	endfunction

	function automatic void pos_of_byte(int unsigned off, output int unsigned ln,
		output int unsigned col);
		int unsigned stop, at;
		logic [7:0] b;
		stop = clamp_len(off);
		at = 0;
		ln = 0;
		col = 0;
		while (at < stop) begin
			b = doc_text[at];
			at += step_at(at);
			if (b == NEWLINE) begin
				ln++;
				col = 0;
			end else begin
				col += lead_units16(b);
			end
		end
	endfunction

	function automatic int unsigned byte_of_pos(logic signed [17:0] line, int unsigned chr);
		int unsigned at, ln, units, goal;
		logic [7:0] b;
		if (line < 0) return 0;
		goal = int'(line);
		at = 0;
		ln = 0;
		units = 0;
		while (ln < goal && at < doc_len) begin
			b = doc_text[at];
			at += step_at(at);
			if (b == NEWLINE) ln++;
		end
		if (ln < goal) return doc_len;
		// stop at the newline that ends the line
		while (at < doc_len && units < chr) begin
			b = doc_text[at];
			if (b == NEWLINE) break;
			units += lead_units16(b);
			at += step_at(at);
		end
		return at;
	endfunction

	function automatic out_item_t predict_answer(logic [2:0] cmd, logic [7:0] data,
		logic [16:0] qoff, logic signed [17:0] line, logic [16:0] chr);
		out_item_t ans;
		int unsigned ln, col;
		ans = '0;
		ans.status = STATUS_OK;
		case (cmd)
			CMD_CLEAR: doc_len = 0;
			CMD_APPEND: begin
				if (doc_len < TEXT_DEPTH) begin
					doc_text[doc_len] = data;
					doc_len++;
				end else begin
					ans.status = STATUS_FULL;
				end
			end
			CMD_UTF16_OF_BYTE: ans.result_offset = 17'(utf16_of_byte(qoff));
			CMD_BYTE_OF_UTF16: ans.result_offset = 17'(byte_of_utf16(qoff));
			CMD_POS_OF_BYTE: begin
				pos_of_byte(qoff, ln, col);
				ans.line_number = 17'(ln);
				ans.column_units = 17'(col);
			end
			CMD_BYTE_OF_POS: ans.result_offset = 17'(byte_of_pos(line, chr));
			default: ;
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_len = 0;
			answers_due.delete();
			fault_count <= 0;
			answers_pending <= 0;
		end else begin
			if (req.valid && req.ready) begin
				pred_item = predict_answer(req.command, req.data_byte,
					req.query_offset, req.line_index, req.char_index);
				answers_due = {answers_due, pred_item};
			end
			if (rsp.valid && rsp.ready) begin
				got_item.status = rsp.status;
				got_item.result_offset = rsp.result_offset;
				got_item.line_number = rsp.line_number;
				got_item.column_units = rsp.column_units;
				if (answers_due.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: result item with none expected:",
							$realtime,
							" status=%0d offset=%0d line=%0d column=%0d",
							got_item.status, got_item.result_offset,
							got_item.line_number, got_item.column_units);
					fault_count <= fault_count + 1;
				end else begin
					want_item = answers_due.pop_front();
					if (got_item.status !== want_item.status
						|| got_item.result_offset !== want_item.result_offset
						|| got_item.line_number !== want_item.line_number
						|| got_item.column_units !== want_item.column_units) begin
						if (fault_count < 10)
							$display("%0t: mismatch: expected", $realtime,
								" status=%0d offset=%0d line=%0d column=%0d,",
								want_item.status, want_item.result_offset,
								want_item.line_number, want_item.column_units,
								" got status=%0d offset=%0d line=%0d column=%0d",
								got_item.status, got_item.result_offset,
								got_item.line_number, got_item.column_units);
						fault_count <= fault_count + 1;
					end
				end
			end
			answers_pending <= answers_due.size();
		end
	end

endmodule

>>> bench/testbench.sv
// top of the utf8 text offset mapper bench: clock, reset, command stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import utom_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int PHASE_ITEMS = 500;

	logic clk = 1'b0;
	logic arst_n;
	int   fault_count, answers_pending;
	int   send_idle_pct, recv_stall_pct;
	int   items_sent;
	int   doc_fill;

	// mixed text: ascii, newline, 2/3/4-byte characters, a bad lead and a cut-off 4-byte lead
	logic [7:0] sample_text [14] = '{8'h61, 8'h0A, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
		8'hF0, 8'h9F, 8'h98, 8'h80, 8'h0A, 8'hFF, 8'hF0};

	utom_req_if req_ch();
	utom_rsp_if rsp_ch();

	utf8_text_offset_mapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	offset_map_checker map_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.fault_count     (fault_count),
		.answers_pending (answers_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic logic signed [17:0] rand_line();
		return 18'($urandom_range(65537)) - 18'd1;
	endfunction

	task automatic push_item(logic [2:0] cmd, logic [7:0] data, logic [16:0] qoff,
		logic signed [17:0] line, logic [16:0] chr);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.data_byte <= data;
		req_ch.query_offset <= qoff;
		req_ch.line_index <= line;
		req_ch.char_index <= chr;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		if (cmd == CMD_CLEAR)
			doc_fill = 0;
		else if (cmd == CMD_APPEND)
			doc_fill++;
	endtask

	task automatic append_byte(logic [7:0] b);
		push_item(CMD_APPEND, b, 17'($urandom), rand_line(), 17'($urandom));
	endtask

	task automatic clear_text();
		push_item(CMD_CLEAR, 8'($urandom), 17'($urandom), rand_line(), 17'($urandom));
	endtask

	task automatic query(logic [2:0] cmd, logic [16:0] qoff, logic signed [17:0] line,
		logic [16:0] chr);
		push_item(cmd, 8'($urandom), qoff, line, chr);
	endtask

	function automatic logic [7:0] cont_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	// mostly well-formed characters, with some raw bytes mixed in
	task automatic append_char();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 20) begin
			append_byte(NEWLINE);
		end else if (pick < 55) begin
			append_byte(8'($urandom_range(127)));
		end else if (pick < 70) begin
			append_byte({3'b110, 5'($urandom)});
			append_byte(cont_byte());
		end else if (pick < 82) begin
			append_byte({4'b1110, 4'($urandom)});
			append_byte(cont_byte());
			append_byte(cont_byte());
		end else if (pick < 92) begin
			append_byte({5'b11110, 3'($urandom)});
			append_byte(cont_byte());
			append_byte(cont_byte());
			append_byte(cont_byte());
		end else begin
			append_byte(8'($urandom));
		end
	endtask

	task automatic random_query();
		int unsigned pick;
		logic [2:0] cmd;
		logic [16:0] qoff, chr;
		logic signed [17:0] line;
		pick = $urandom_range(99);
		if (pick < 22)
			cmd = CMD_UTF16_OF_BYTE;
		else if (pick < 44)
			cmd = CMD_BYTE_OF_UTF16;
		else if (pick < 66)
			cmd = CMD_POS_OF_BYTE;
		else if (pick < 92)
			cmd = CMD_BYTE_OF_POS;
		else if (pick < 96)
			cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
		else
			cmd = CMD_APPEND;
		qoff = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(doc_fill + 4));
		pick = $urandom_range(9);
		if (pick == 0)
			line = -18'sd1;
		else if (pick == 1)
			line = rand_line();
		else
			line = 18'($urandom_range(6));
		chr = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(12));
		push_item(cmd, 8'($urandom), qoff, line, chr);
	endtask

	// short documents keep the walks short
	task automatic run_phase(int idle_pct, int stall_pct);
		int first;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			if (doc_fill > 64 || $urandom_range(99) < 60)
				clear_text();
			repeat ($urandom_range(16)) append_char();
			repeat ($urandom_range(12, 3)) random_query();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_CLEAR;
		req_ch.data_byte = '0;
		req_ch.query_offset = '0;
		req_ch.line_index = '0;
		req_ch.char_index = '0;
		rsp_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		doc_fill = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty text, negative line
		query(CMD_BYTE_OF_POS, 17'($urandom), -18'sd1, 17'($urandom));
		foreach (sample_text[i]) append_byte(sample_text[i]);
		query(CMD_UTF16_OF_BYTE, 17'd3, 18'sd0, 17'd0);
		query(CMD_UTF16_OF_BYTE, 17'h1FFFF, 18'sd0, 17'd0);
		query(CMD_BYTE_OF_UTF16, 17'd5, 18'sd0, 17'd0);
		query(CMD_BYTE_OF_UTF16, 17'h1FFFF, 18'sd0, 17'd0);
		query(CMD_POS_OF_BYTE, 17'd9, 18'sd0, 17'd0);
		query(CMD_BYTE_OF_POS, 17'd0, 18'sd1, 17'h1FFFF);
		query(CMD_BYTE_OF_POS, 17'd0, 18'sd65536, 17'd0);
		query(CMD_SPARE_LO, 17'h1FFFF, -18'sd1, 17'h1FFFF);
		query(CMD_SPARE_HI, 17'h1FFFF, 18'sd65536, 17'h1FFFF);
		clear_text();

		run_phase(0, 0);
		run_phase(45, 0);
		run_phase(0, 45);
		run_phase(37, 37);

		@(negedge clk) req_ch.valid <= 1'b0;
		wait (answers_pending == 0);
		repeat (400) @(posedge clk);
		if (fault_count == 0 && answers_pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#50ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
